FILE: hw/rtl/gamf_pkg.sv
package gamf_pkg;

  // Field and register widths of the block's ports.
  localparam int unsigned PIXEL_IN_W = 16;
  localparam int unsigned ACC_W      = 24;
  localparam int unsigned WCFG_W     = 11;
  localparam int unsigned HCFG_W     = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Frame size limits and register reset values.
  localparam int unsigned MIN_DIM      = 3;
  localparam int unsigned HEIGHT_MAX   = 4096;
  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;

  // Largest gradient for 16-bit pixels: two absolute differences.
  localparam logic [ACC_W-1:0] GRAD_MAX = 24'h01FFFE;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_ACC_MODE = 2'd2
  } gamf_cfg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } gamf_op_e;

  // Classification of a request as it moves from the input stage to the result stage.
  typedef struct packed {
    logic pixel;
    logic emit;
    logic have_g;
    logic border_row;
    logic eof;
  } gamf_item_t;

endpackage

FILE: hw/rtl/gradient_abs_magnitude_filter_top.sv
// L1 gradient magnitude over a raster stream of unsigned 8.8 pixels.
// Input channel (in_valid_i/in_ready_o): one request per pixel or flush, one per cycle while in_ready_o is high.
// Output channel (out_valid_o/out_ready_i): at most one result per request.
// Configuration channel (cfg_valid_i/cfg_ready_o) is always ready; write it only when idle.
// Throughput is one request per cycle while in_ready_o is high. A request is registered at
// acceptance, while both line stores are read at the current column, and its result is
// loaded into the output register when the request leaves the input stage.
// The result for a pixel position arrives with the request one row plus one column later;
// after the last pixel of a frame, width + 1 flush requests drain the remaining results,
// or the next frame's pixels push them out.
// After reset the two line stores are cleared one entry per cycle through all MAX_WIDTH entries,
// and in_ready_o stays low meanwhile. Configuration writes are taken during that time.
// When the receiver stalls, the output register holds its result. Requests that owe no
// result still pass; the first one that owes a result waits in the input stage and
// in_ready_o stays low until the held result is taken.
module gradient_abs_magnitude_filter_top import gamf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [PIXEL_IN_W-1:0] pixel_i,
  input  logic [ACC_W-1:0]      acc_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ACC_W-1:0]      gradient_out_o,
  output logic                  end_of_frame_o
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W = (PIXEL_BITS < PIXEL_IN_W) ? PIXEL_BITS : PIXEL_IN_W;

  logic [WCFG_W-1:0] width_q;
  logic [HCFG_W-1:0] height_q;
  logic              acc_mode_q;
  logic              s1_valid_q, out_valid_q, eof_q;
  logic              accept, s1_adv, load_out, busy;
  logic [AW-1:0]     col;
  logic [PIX_W:0]    grad;
  logic [ACC_W-1:0]  acc_q, result_d, gradient_q;
  logic [ACC_W:0]    acc_sum;
  gamf_item_t        item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WCFG_W'(WIDTH_RESET);
      height_q   <= HCFG_W'(HEIGHT_RESET);
      acc_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (gamf_cfg_e'(cfg_index_i))
        CFG_WIDTH:    width_q    <= cfg_data_i[WCFG_W-1:0];
        CFG_HEIGHT:   height_q   <= cfg_data_i[HCFG_W-1:0];
        CFG_ACC_MODE: acc_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // A request without a result leaves the input stage even while the output is stalled.
  assign s1_adv     = s1_valid_q && (!item.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !busy && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = s1_adv && item.emit;

  gamf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .flush_i  (op_i == OP_FLUSH),
    .width_i  (width_q),
    .height_i (height_q),
    .col_o    (col),
    .item_o   (item)
  );

  gamf_linebuf #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIX_W     (PIX_W)
  ) u_linebuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept && (op_i == OP_PIXEL)),
    .addr_i  (col),
    .pixel_i (pixel_i[PIX_W-1:0]),
    .adv_i   (s1_adv && item.pixel),
    .busy_o  (busy),
    .grad_o  (grad)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= acc_in_i;
    end
  end

  always_comb begin
    acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(grad);
    if (item.have_g) begin
      if (acc_mode_q) begin
        result_d = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
      end else begin
        result_d = ACC_W'(grad);
      end
    end else if (item.border_row && acc_mode_q) begin
      result_d = acc_q;
    end else begin
      result_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      gradient_q <= result_d;
      eof_q      <= item.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gradient_out_o = gradient_q;
  assign end_of_frame_o = eof_q;

endmodule

FILE: hw/rtl/gamf_ctrl.sv
module gamf_ctrl import gamf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned AW = $clog2(MAX_WIDTH),
  localparam int unsigned CW = ((AW + 1) > WCFG_W) ? (AW + 1) : WCFG_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              flush_i,
  input  logic [WCFG_W-1:0] width_i,
  input  logic [HCFG_W-1:0] height_i,
  output logic [AW-1:0]     col_o,
  output gamf_item_t        item_o
);

  logic [CW-1:0]     w_ext, eff_w, wp1, wm1, col_ext, col_inc;
  logic [CW-1:0]     pend_q, pend_d, pend_c, qc;
  logic [HCFG_W-1:0] eff_h, hm1, hm2, row_ext, row_inc, qr;
  logic [AW-1:0]     col_q, col_d, col_c;
  logic [ROW_W-1:0]  row_q, row_d, row_c;
  logic              out_of_frame;
  gamf_item_t        item_q, item_d;

  always_comb begin
    w_ext = CW'(width_i);
    if (w_ext < CW'(MIN_DIM)) begin
      eff_w = CW'(MIN_DIM);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    if (height_i < HCFG_W'(MIN_DIM)) begin
      eff_h = HCFG_W'(MIN_DIM);
    end else if (height_i > HCFG_W'(HEIGHT_MAX)) begin
      eff_h = HCFG_W'(HEIGHT_MAX);
    end else begin
      eff_h = height_i;
    end
    wp1 = eff_w + CW'(1);
    wm1 = eff_w - CW'(1);
    hm1 = eff_h - HCFG_W'(1);
    hm2 = eff_h - HCFG_W'(2);
  end

  // A size change can leave the position outside the new frame; it then restarts.
  always_comb begin
    out_of_frame = (CW'(col_q) >= eff_w) || (HCFG_W'(row_q) >= eff_h);
    col_c   = out_of_frame ? '0 : col_q;
    row_c   = out_of_frame ? '0 : row_q;
    col_ext = CW'(col_c);
    row_ext = HCFG_W'(row_c);
    col_inc = col_ext + CW'(1);
    row_inc = row_ext + HCFG_W'(1);
    pend_c  = (pend_q > wp1) ? wp1 : pend_q;
  end

  always_comb begin
    item_d = '0;
    col_d  = col_c;
    row_d  = row_c;
    pend_d = pend_c;
    qc     = '0;
    qr     = '0;
    if (flush_i) begin
      item_d.emit = (col_c == '0) && (row_c == '0) && (pend_c != '0);
      if (item_d.emit) begin
        pend_d = pend_c - CW'(1);
      end
      // Flushes drain the tail of the previous frame, counted back from its end.
      if (pend_c == wp1) begin
        qr = hm2;
        qc = wm1;
      end else begin
        qr = hm1;
        qc = eff_w - pend_c;
      end
    end else begin
      item_d.pixel  = 1'b1;
      item_d.emit   = (pend_c == wp1);
      item_d.have_g = (row_c >= ROW_W'(2)) && (col_c >= AW'(2));
      if (!item_d.emit) begin
        pend_d = pend_c + CW'(1);
      end
      if (col_inc >= eff_w) begin
        col_d = '0;
        row_d = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[AW-1:0];
      end
      // The result is for the position one row plus one column back.
      if (col_c != '0) begin
        qc = col_ext - CW'(1);
        qr = (row_c == '0) ? hm1 : row_ext - HCFG_W'(1);
      end else begin
        qc = wm1;
        if (row_c == '0) begin
          qr = hm2;
        end else if (row_c == ROW_W'(1)) begin
          qr = hm1;
        end else begin
          qr = row_ext - HCFG_W'(2);
        end
      end
    end
    item_d.border_row = (qr == '0) || (qr == hm1);
    item_d.eof        = (qr == hm1) && (qc == wm1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
      item_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      item_q <= item_d;
    end
  end

  assign col_o  = col_c;
  assign item_o = item_q;

endmodule

FILE: hw/rtl/gamf_linebuf.sv
module gamf_linebuf import gamf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned PIX_W     = 16,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             adv_i,
  output logic             busy_o,
  output logic [PIX_W:0]   grad_o
);

  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];
  logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
  logic [PIX_W-1:0] rd_mid_q, rd_up_q, px_q;
  logic [PIX_W-1:0] mid_h1_q, mid_h2_q, up_h1_q, px_h1_q;
  logic [AW-1:0]    addr_q, clr_q;
  logic             busy_q;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Both line stores are zeroed one entry per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == AW'(MAX_WIDTH - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_mid[clr_q] <= '0;
    end else if (wr_en_i) begin
      rd_mid_q        <= mem_mid[addr_i];
      mem_mid[addr_i] <= pixel_i;
    end
  end

  // The upper store takes the evicted middle value once the request leaves the input stage.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_up[clr_q] <= '0;
    end else begin
      if (wr_en_i) begin
        rd_up_q <= mem_up[addr_i];
      end
      if (adv_i) begin
        mem_up[addr_q] <= rd_mid_q;
      end
    end
  end

  // Values read for the previous two columns stand in for the left and above neighbors.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      addr_q <= addr_i;
      px_q   <= pixel_i;
    end
    if (adv_i) begin
      mid_h1_q <= rd_mid_q;
      mid_h2_q <= mid_h1_q;
      up_h1_q  <= rd_up_q;
      px_h1_q  <= px_q;
    end
  end

  assign busy_o = busy_q;
  assign grad_o = {1'b0, abs_diff(rd_mid_q, mid_h2_q)} + {1'b0, abs_diff(px_h1_q, up_h1_q)};

endmodule

FILE: hw/rtl/gamf_checker.sv
module gamf_checker import gamf_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [ACC_W-1:0]      gradient_out_o,
  input logic                  end_of_frame_o
);

  logic mode_q;

  // Shadow of the accumulate mode register, seen from the configuration channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_ACC_MODE)) begin
      mode_q <= cfg_data_i[0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while the receiver stalls");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(gradient_out_o) && $stable(end_of_frame_o))
    else $error("stalled result changed");

  a_grad_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q |-> gradient_out_o <= GRAD_MAX)
    else $error("gradient exceeds two pixel differences outside accumulate mode");

  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a request two cycles earlier");

endmodule

bind gradient_abs_magnitude_filter_top gamf_checker u_gamf_checker (.*);
